// ----- src/mhs_pkg.sv -----
`default_nettype none
package mhs_pkg;
    localparam int KEY_W      = 32;
    localparam int STATUS_W   = 3;
    localparam int OP_W       = 2;
    localparam int DEF_CAPACITY = 64;

    localparam logic [OP_W-1:0] OP_LOAD     = 2'd0;
    localparam logic [OP_W-1:0] OP_INCREASE = 2'd1;
    localparam logic [OP_W-1:0] OP_SORT     = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_IDX = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SMALLER = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

    typedef logic signed [KEY_W-1:0] key_t;
endpackage
`default_nettype wire

// ----- src/mhs_ram.sv -----
`default_nettype none
module mhs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- src/max_heap_sort_engine.sv -----
`default_nettype none
// Binary max-heap over up to CAPACITY signed 32-bit keys, kept in one
// single-port-read RAM and walked by a small sequencer with one key comparator.
// Each store read is registered (address, then registered read data), so
// a plain load only writes its key, while a final load, increase or sort
// runs heap build and sift steps, level by level, and a sort of N keys then
// emits every stored key as its own result beat.
// The input stall stays high until every result beat of an item has been taken.
module max_heap_sort_engine #(
    parameter int CAPACITY = mhs_pkg::DEF_CAPACITY
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         in_valid,
    output logic                        in_stall,
    input  wire  [mhs_pkg::OP_W-1:0]    opcode,
    input  wire  mhs_pkg::key_t         key_value,
    input  wire  [5:0]                  slot_index,
    input  wire                         final_load,
    output logic                        out_valid,
    input  wire                         out_stall,
    output mhs_pkg::key_t               result_value,
    output logic [mhs_pkg::STATUS_W-1:0] status,
    output logic                        end_of_run
);
    import mhs_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_BUILD = 5'd1;  // pick next build node
    localparam logic [4:0] S_SD_P  = 5'd2;  // read parent
    localparam logic [4:0] S_SD_L  = 5'd3;
    localparam logic [4:0] S_SD_R  = 5'd4;
    localparam logic [4:0] S_SD_D  = 5'd5;  // decide
    localparam logic [4:0] S_SD_W1 = 5'd6;
    localparam logic [4:0] S_SD_W2 = 5'd7;
    localparam logic [4:0] S_AFTER = 5'd8;  // heap ready, dispatch op
    localparam logic [4:0] S_IN_CK = 5'd10;
    localparam logic [4:0] S_UP_RD = 5'd11;
    localparam logic [4:0] S_UP_CK = 5'd12;
    localparam logic [4:0] S_MAXRD = 5'd14;
    localparam logic [4:0] S_MAXW  = 5'd15;
    localparam logic [4:0] S_SO_LR = 5'd16; // read last
    localparam logic [4:0] S_SO_W  = 5'd17;
    localparam logic [4:0] S_EM_RD = 5'd18;
    localparam logic [4:0] S_EM_W  = 5'd19;
    localparam logic [4:0] S_OUT   = 5'd20;
    localparam logic [4:0] S_SO_0R = 5'd21; // read root

    logic [4:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ordered_reg, ordered_next;
    logic [OP_W-1:0] op_reg, op_next;
    key_t          key_reg, key_next;
    logic [5:0]    slot_reg, slot_next;
    logic [CW-1:0] build_reg, build_next;   // nodes still to sift in build
    logic [CW-1:0] size_reg, size_next;     // sift-down heap size
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] top_reg, top_next;
    key_t          pk_reg, pk_next;         // key at pos
    key_t          tk_reg, tk_next;         // key of current top
    key_t          hold_reg, hold_next;
    logic [CW-1:0] emi_reg, emi_next;
    key_t          res_reg, res_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic          eor_reg, eor_next;
    logic          ov_reg, ov_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    key_t          wdata;
    logic [KEY_W-1:0] rdata;
    key_t          rkey;

    logic [CW:0]   left_w, right_w, par_w;

    key_t          cmp_a, cmp_b;
    logic          cmp_gt;

    mhs_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_store (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign rkey         = key_t'(rdata);
    assign in_stall     = (state_reg != S_IDLE) || ov_reg;
    assign out_valid    = ov_reg;
    assign result_value = res_reg;
    assign status       = st_reg;
    assign end_of_run   = eor_reg;
    assign left_w       = {pos_reg, 1'b1};
    assign right_w      = {pos_reg, 1'b0} + (CW+1)'(2);
    assign par_w        = (CW+1)'(pos_reg - CW'(1)) >> 1;

    // the one signed comparator, operands picked by state
    always_comb
    begin
        case (state_reg)
            S_IN_CK:
            begin
                cmp_a = rkey;
                cmp_b = key_reg;
            end
            S_UP_CK:
            begin
                cmp_a = key_reg;
                cmp_b = rkey;
            end
            default:
            begin
                cmp_a = rkey;
                cmp_b = tk_reg;
            end
        endcase
    end

    assign cmp_gt = (cmp_a > cmp_b);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ordered_next = ordered_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        slot_next    = slot_reg;
        build_next   = build_reg;
        size_next    = size_reg;
        pos_next     = pos_reg;
        top_next     = top_reg;
        pk_next      = pk_reg;
        tk_next      = tk_reg;
        hold_next    = hold_reg;
        emi_next     = emi_reg;
        res_next     = res_reg;
        st_next      = st_reg;
        eor_next     = eor_reg;
        ov_next      = ov_reg;
        we           = 1'b0;
        waddr        = '0;
        wdata        = key_reg;
        raddr        = '0;
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    op_next   = opcode;
                    key_next  = key_value;
                    slot_next = slot_index;
                    case (opcode)
                        OP_LOAD:
                        begin
                            if (count_reg >= CAP)
                            begin
                                res_next = '0; st_next = ST_FULL; eor_next = 1'b1;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                we = 1'b1;
                                waddr = AW'(count_reg);
                                wdata = key_value;
                                count_next = count_reg + CW'(1);
                                ordered_next = 1'b0;
                                if (final_load)
                                begin
                                    build_next = (count_reg + CW'(1)) >> 1;
                                    state_next = S_BUILD;
                                end
                            end
                        end
                        OP_INCREASE, OP_SORT:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next = '0; st_next = ST_EMPTY; eor_next = 1'b1;
                                state_next = S_OUT;
                            end
                            else if (ordered_reg)
                            begin
                                state_next = S_AFTER;
                            end
                            else
                            begin
                                build_next = count_reg >> 1;
                                state_next = S_BUILD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_BUILD:
            begin
                if (build_reg == '0)
                begin
                    ordered_next = 1'b1;
                    state_next = S_AFTER;
                end
                else
                begin
                    pos_next  = build_reg - CW'(1);
                    build_next = build_reg - CW'(1);
                    size_next = count_reg;
                    raddr = AW'(build_reg - CW'(1));
                    state_next = S_SD_P;
                end
            end
            S_SD_P:
            begin
                // data for pos arrives now, issue left read
                pk_next = rkey;
                tk_next = rkey;
                top_next = pos_reg;
                if (left_w < (CW+1)'(size_reg))
                begin
                    raddr = AW'(left_w);
                    state_next = S_SD_L;
                end
                else
                begin
                    state_next = S_SD_D;
                end
            end
            S_SD_L:
            begin
                if (cmp_gt)
                begin
                    tk_next = rkey;
                    top_next = CW'(left_w);
                end
                if (right_w < (CW+1)'(size_reg))
                begin
                    raddr = AW'(right_w);
                    state_next = S_SD_R;
                end
                else
                begin
                    state_next = S_SD_D;
                end
            end
            S_SD_R:
            begin
                if (cmp_gt)
                begin
                    tk_next = rkey;
                    top_next = CW'(right_w);
                end
                state_next = S_SD_D;
            end
            S_SD_D:
            begin
                if (top_reg == pos_reg)
                begin
                    state_next = (op_reg == OP_SORT && ordered_reg) ? S_SO_LR : S_BUILD;
                end
                else
                begin
                    we = 1'b1; waddr = AW'(pos_reg); wdata = tk_reg;
                    state_next = S_SD_W1;
                end
            end
            S_SD_W1:
            begin
                we = 1'b1; waddr = AW'(top_reg); wdata = pk_reg;
                pos_next = top_reg;
                state_next = S_SD_W2;
            end
            S_SD_W2:
            begin
                raddr = AW'(pos_reg);
                state_next = S_SD_P;
            end
            S_AFTER:
            begin
                if (op_reg == OP_INCREASE)
                begin
                    if ({1'b0, slot_reg} >= 7'(count_reg))
                    begin
                        st_next = ST_BAD_IDX;
                        state_next = S_MAXRD;
                    end
                    else
                    begin
                        raddr = AW'(slot_reg);
                        state_next = S_IN_CK;
                    end
                end
                else if (op_reg == OP_SORT)
                begin
                    size_next = count_reg;
                    state_next = S_SO_LR;
                end
                else
                begin
                    st_next = ST_OK;
                    state_next = S_MAXRD;
                end
            end
            S_IN_CK:
            begin
                if (cmp_gt)
                begin
                    st_next = ST_SMALLER;
                    state_next = S_MAXRD;
                end
                else
                begin
                    pos_next = CW'(slot_reg);
                    state_next = S_UP_RD;
                end
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    we = 1'b1; waddr = '0; wdata = key_reg;
                    st_next = ST_OK;
                    state_next = S_MAXRD;
                end
                else
                begin
                    raddr = AW'(par_w);
                    state_next = S_UP_CK;
                end
            end
            S_UP_CK:
            begin
                if (cmp_gt)
                begin
                    we = 1'b1; waddr = AW'(pos_reg); wdata = rkey;
                    pos_next = CW'(par_w);
                    state_next = S_UP_RD;
                end
                else
                begin
                    we = 1'b1; waddr = AW'(pos_reg); wdata = key_reg;
                    st_next = ST_OK;
                    state_next = S_MAXRD;
                end
            end
            S_MAXRD:
            begin
                raddr = '0;
                state_next = S_MAXW;
            end
            S_MAXW:
            begin
                res_next = rkey; eor_next = 1'b1;
                state_next = S_OUT;
            end
            S_SO_LR:
            begin
                // heapsort step: swap root with last of current size
                if (size_reg <= CW'(1))
                begin
                    emi_next = '0;
                    state_next = S_EM_RD;
                end
                else
                begin
                    raddr = AW'(size_reg - CW'(1));
                    state_next = S_SO_0R;
                end
            end
            S_SO_0R:
            begin
                hold_next = rkey;
                raddr = '0;
                state_next = S_SO_W;
            end
            S_SO_W:
            begin
                we = 1'b1; waddr = AW'(size_reg - CW'(1)); wdata = rkey;
                pk_next = hold_reg;
                size_next = size_reg - CW'(1);
                pos_next = '0;
                // root gets the old last key next, in S_SD_W1
                state_next = S_SD_W1;
                top_next = '0;
            end
            S_EM_RD:
            begin
                raddr = AW'(emi_reg);
                state_next = S_EM_W;
            end
            S_EM_W:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    res_next = rkey; st_next = ST_OK;
                    eor_next = (emi_reg + CW'(1) == count_reg);
                    emi_next = emi_reg + CW'(1);
                    if (emi_reg + CW'(1) == count_reg)
                    begin
                        count_next = '0;
                        ordered_next = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_EM_RD;
                    end
                end
                else
                begin
                    raddr = AW'(emi_reg);
                end
            end
            S_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            ordered_reg <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ordered_reg <= ordered_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        key_reg  <= key_next;
        slot_reg <= slot_next;
        build_reg <= build_next;
        size_reg <= size_next;
        pos_reg  <= pos_next;
        top_reg  <= top_next;
        pk_reg   <= pk_next;
        tk_reg   <= tk_next;
        hold_reg <= hold_next;
        emi_reg  <= emi_next;
        res_reg  <= res_next;
        st_reg   <= st_next;
        eor_reg  <= eor_next;
    end

`ifndef ASSERT_OFF
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP) else $error("entry count above capacity");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && out_stall |=> ov_reg && $stable(res_reg))
        else $error("stalled result changed");
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_sort_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EM_W && state_next == S_IDLE |=> count_reg == '0)
        else $error("store not emptied after sort");
`endif
endmodule
`default_nettype wire
